/* design/sbp_pkg.sv */
// Shared types and constants for the shuffle bag picker.
// No dependencies; imported by sbp_gen, the top level and the testbench.
package sbp_pkg;

  localparam int unsigned BAG_DEPTH_DEF = 32;

  localparam int unsigned ID_W    = 7;
  localparam int unsigned GRP_W   = 3;
  localparam int unsigned ENTRY_W = ID_W + GRP_W;
  localparam int unsigned ROUND_W = 10;
  localparam int unsigned SEED_W  = 14;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned YIELD_W = 16;

  localparam logic [SEED_W-1:0] SEED_LIMIT = 14'd9999;
  localparam logic [SEED_W-1:0] SEED_WRAP  = 14'd10000;

  localparam logic [WORD_W-1:0] SEED_MUL = 32'd2654435761;
  localparam logic [WORD_W-1:0] LCG_MUL  = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD  = 32'd1013904223;

  localparam logic [ROUND_W-1:0] CHANCE_RESET = 10'd8;
  localparam logic [ROUND_W-1:0] ALWAYS_RESET = 10'd12;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_START  = 2'd2,
    KIND_DRAW   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_SEED          = 2'd0,
    REG_MIRROR_CHANCE = 2'd1,
    REG_MIRROR_ALWAYS = 2'd2
  } cfg_reg_e;

  // Requests from the sequencer to the generator unit
  typedef struct packed {
    logic seed_load;
    logic range_go;
  } gen_req_t;

endpackage

/* design/sbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sbp_gen.sv */
// Generator unit: 32-bit LCG word plus a bit-serial remainder of its yield.
// Depends on sbp_pkg.
module sbp_gen #(
  parameter int unsigned BAG_DEPTH = sbp_pkg::BAG_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbp_pkg::gen_req_t            req_i,
  input  logic [sbp_pkg::SEED_W-1:0]   seed_i,
  input  logic [$clog2(BAG_DEPTH)-1:0] range_m_i,
  output logic                         done_o,
  output logic [$clog2(BAG_DEPTH)-1:0] result_o
);
  import sbp_pkg::*;

  localparam int unsigned AW = $clog2(BAG_DEPTH);
  localparam int unsigned CW = $clog2(BAG_DEPTH + 1);

  typedef enum logic [1:0] {
    G_IDLE,
    G_STEP,
    G_DIV
  } gstate_e;

  gstate_e             state_q;
  logic [WORD_W-1:0]   word_q;
  logic [CW-1:0]       div_q;
  logic [CW-1:0]       rem_q;
  logic [3:0]          bit_q;
  logic                done_q;

  logic [YIELD_W-1:0]  yield;
  logic [CW:0]         trial;
  logic [CW:0]         diff;

  assign yield = word_q[WORD_W-1:WORD_W-YIELD_W];
  assign trial = {rem_q, yield[bit_q]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      word_q  <= '0;
      div_q   <= '0;
      rem_q   <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        G_IDLE: begin
          if (req_i.seed_load) begin
            word_q <= WORD_W'({18'd0, seed_i} * SEED_MUL) + WORD_W'(1);
          end else if (req_i.range_go) begin
            if (range_m_i == '0) begin
              // range of zero: no step, result zero
              rem_q  <= '0;
              done_q <= 1'b1;
            end else begin
              div_q   <= CW'(range_m_i) + CW'(1);
              state_q <= G_STEP;
            end
          end
        end
        G_STEP: begin
          word_q  <= word_q * LCG_MUL + LCG_ADD;
          rem_q   <= '0;
          bit_q   <= 4'd15;
          state_q <= G_DIV;
        end
        G_DIV: begin
          // restoring remainder, one yield bit per cycle, msb first
          if (trial >= {1'b0, div_q}) begin
            rem_q <= diff[CW-1:0];
          end else begin
            rem_q <= trial[CW-1:0];
          end
          bit_q <= bit_q - 4'd1;
          if (bit_q == 4'd0) begin
            done_q  <= 1'b1;
            state_q <= G_IDLE;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = rem_q[AW-1:0];

endmodule

/* design/shuffle_bag_picker.sv */
// Shuffle bag picker top level: command sequencer, bag RAM and generator unit.
// Depends on sbp_pkg, sbp_ram and sbp_gen.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser kind, tdata id/group/round
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser status, tdata id/group/mirror
//  cfg       in   cfg_we_i                        cfg_idx_i, cfg_wdata_i
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Clear, append and a draw from an empty bag go straight to the output state; a plain
// draw first reads its bag entry, then waits on the generator if the mirror bit is a coin flip.
// A shuffle does one swap per bag entry above the first, each one waiting on the
// 16-step remainder loop of the generator unit, then on the RAM swap states RDA, RDB, WRA, WRB.
// The bag RAM holds no reset state; only control registers are cleared.
// A result waits in the output register; the next item is taken meanwhile.
module shuffle_bag_picker #(
  parameter int unsigned BAG_DEPTH = sbp_pkg::BAG_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // item_id, item_group, round, pad
  input  logic [1:0]                  s_axis_tuser,  // kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // drawn_id, drawn_group, mirrored, pad
  output logic [1:0]                  m_axis_tuser,  // status
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [sbp_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import sbp_pkg::*;

  localparam int unsigned AW = $clog2(BAG_DEPTH);
  localparam int unsigned CW = $clog2(BAG_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_SH_TEST,
    ST_SH_WAIT,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_WRA,
    ST_SW_WRB,
    ST_FIX,
    ST_FIX_CHK,
    ST_FETCH,
    ST_FETCH_CAP,
    ST_MIR_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       slot_q;
  logic [CW-1:0]       idx_q;
  logic                prev_valid_q;
  logic [ID_W-1:0]     prev_id_q;
  logic [AW-1:0]       swap_a_q;
  logic [AW-1:0]       swap_b_q;
  logic [ENTRY_W-1:0]  hold_q;
  logic                fix_q;
  logic                op_draw_q;
  logic [ROUND_W-1:0]  round_q;
  logic [ID_W-1:0]     res_id_q;
  logic [GRP_W-1:0]    res_grp_q;
  logic                res_mir_q;
  status_e             res_status_q;
  logic                m_valid_q;
  logic [15:0]         m_data_q;
  logic [1:0]          m_user_q;
  logic [SEED_W-1:0]   seed_q;
  logic [ROUND_W-1:0]  chance_q;
  logic [ROUND_W-1:0]  always_q;

  logic                in_acc;
  kind_e               kind;
  logic [ID_W-1:0]     in_id;
  logic [GRP_W-1:0]    in_grp;
  logic [ROUND_W-1:0]  in_round;
  logic                bag_full;
  logic [CW-1:0]       idx_m1;
  logic [CW-1:0]       count_m1;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  gen_req_t            gen_req;
  logic [AW-1:0]       gen_m;
  logic                gen_done;
  logic [AW-1:0]       gen_result;
  logic                mir_coin;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_e'(s_axis_tuser);
  assign in_id         = s_axis_tdata[ID_W-1:0];
  assign in_grp        = s_axis_tdata[ENTRY_W-1:ID_W];
  assign in_round      = s_axis_tdata[ENTRY_W+ROUND_W-1:ENTRY_W];
  assign bag_full      = (count_q >= CW'(BAG_DEPTH));
  assign idx_m1        = idx_q - CW'(1);
  assign count_m1      = count_q - CW'(1);
  assign mir_coin      = (round_q < always_q) && (round_q >= chance_q);

  // configuration writes; the seed is folded into range once here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      chance_q <= CHANCE_RESET;
      always_q <= ALWAYS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEED: begin
          if (cfg_wdata_i > SEED_LIMIT) begin
            seed_q <= cfg_wdata_i - SEED_WRAP;
          end else begin
            seed_q <= cfg_wdata_i;
          end
        end
        REG_MIRROR_CHANCE: chance_q <= cfg_wdata_i[ROUND_W-1:0];
        REG_MIRROR_ALWAYS: always_q <= cfg_wdata_i[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // RAM port and generator request steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = swap_a_q;
    ram_wdata = ram_rdata;
    ram_raddr = swap_a_q;
    gen_req   = '0;
    gen_m     = idx_m1[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        ram_we    = in_acc && (kind == KIND_APPEND) && !bag_full;
        ram_waddr = count_q[AW-1:0];
        ram_wdata = {in_grp, in_id};
      end
      ST_SEED:      gen_req.seed_load = 1'b1;
      ST_SH_TEST:   gen_req.range_go = (idx_q > CW'(1));
      ST_SW_RDB:    ram_raddr = swap_b_q;
      ST_SW_WRA:    ram_we = 1'b1;
      ST_SW_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = swap_b_q;
        ram_wdata = hold_q;
      end
      ST_FIX:       ram_raddr = '0;
      ST_FETCH:     ram_raddr = slot_q[AW-1:0];
      ST_FETCH_CAP: begin
        gen_req.range_go = mir_coin;
        gen_m            = AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      slot_q       <= '0;
      idx_q        <= '0;
      prev_valid_q <= 1'b0;
      prev_id_q    <= '0;
      swap_a_q     <= '0;
      swap_b_q     <= '0;
      hold_q       <= '0;
      fix_q        <= 1'b0;
      op_draw_q    <= 1'b0;
      round_q      <= '0;
      res_id_q     <= '0;
      res_grp_q    <= '0;
      res_mir_q    <= 1'b0;
      res_status_q <= ST_OK;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_id_q     <= '0;
            res_grp_q    <= '0;
            res_mir_q    <= 1'b0;
            res_status_q <= ST_OK;
            round_q      <= in_round;
            idx_q        <= count_q;
            op_draw_q    <= (kind == KIND_DRAW);
            state_q      <= ST_DONE;
            unique case (kind)
              KIND_CLEAR: begin
                count_q <= '0;
                slot_q  <= '0;
              end
              KIND_APPEND: begin
                if (bag_full) begin
                  res_status_q <= ST_DROP;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              KIND_START: state_q <= ST_SEED;
              KIND_DRAW: begin
                if (count_q == '0) begin
                  res_status_q <= ST_EMPTY;
                end else if (slot_q >= count_q) begin
                  state_q <= ST_SH_TEST;
                end else begin
                  state_q <= ST_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEED: state_q <= ST_SH_TEST;
        ST_SH_TEST: begin
          if (idx_q > CW'(1)) begin
            swap_a_q <= idx_m1[AW-1:0];
            state_q  <= ST_SH_WAIT;
          end else begin
            slot_q <= '0;
            if (op_draw_q) begin
              state_q <= ST_FIX;
            end else begin
              prev_valid_q <= 1'b0;
              state_q      <= ST_DONE;
            end
          end
        end
        ST_SH_WAIT: begin
          if (gen_done) begin
            swap_b_q <= gen_result;
            fix_q    <= 1'b0;
            state_q  <= ST_SW_RDA;
          end
        end
        ST_SW_RDA: state_q <= ST_SW_RDB;
        ST_SW_RDB: begin
          hold_q  <= ram_rdata;
          state_q <= ST_SW_WRA;
        end
        ST_SW_WRA: state_q <= ST_SW_WRB;
        ST_SW_WRB: begin
          if (fix_q) begin
            state_q <= ST_FETCH;
          end else begin
            idx_q   <= idx_m1;
            state_q <= ST_SH_TEST;
          end
        end
        ST_FIX: state_q <= ST_FIX_CHK;
        ST_FIX_CHK: begin
          // first entry repeats the last draw: swap it with the last entry
          if ((count_q > CW'(1)) && prev_valid_q && (ram_rdata[ID_W-1:0] == prev_id_q)) begin
            swap_a_q <= '0;
            swap_b_q <= count_m1[AW-1:0];
            fix_q    <= 1'b1;
            state_q  <= ST_SW_RDA;
          end else begin
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_FETCH_CAP;
        ST_FETCH_CAP: begin
          res_id_q     <= ram_rdata[ID_W-1:0];
          res_grp_q    <= ram_rdata[ENTRY_W-1:ID_W];
          prev_id_q    <= ram_rdata[ID_W-1:0];
          prev_valid_q <= 1'b1;
          slot_q       <= slot_q + CW'(1);
          if (round_q >= always_q) begin
            res_mir_q <= 1'b1;
            state_q   <= ST_DONE;
          end else if (mir_coin) begin
            state_q <= ST_MIR_WAIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MIR_WAIT: begin
          if (gen_done) begin
            res_mir_q <= gen_result[0];
            state_q   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {5'd0, res_mir_q, res_grp_q, res_id_q};
            m_user_q  <= res_status_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  sbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BAG_DEPTH)
  ) u_bag (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sbp_gen #(
    .BAG_DEPTH (BAG_DEPTH)
  ) u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (gen_req),
    .seed_i    (seed_q),
    .range_m_i (gen_m),
    .done_o    (gen_done),
    .result_o  (gen_result)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BAG_DEPTH))
    else $error("bag count above depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= count_q)
    else $error("draw slot beyond bag count");

  a_gen_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_done |-> (state_q == ST_SH_WAIT || state_q == ST_MIR_WAIT))
    else $error("generator result with no one waiting");

  a_full_append_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind == KIND_APPEND && bag_full) |=> (count_q == $past(count_q)))
    else $error("dropped append changed the bag");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata == '0))
    else $error("empty draw with non-zero payload");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking bench for the shuffle bag picker: directed commands, then random
// command sequences under several register settings. Needs sbp_pkg and the DUT.
`timescale 1ns / 100ps

module testbench;
  import sbp_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam logic [31:0] SEED_MULT   = 32'd2654435761;
  localparam logic [31:0] LCG_MULT    = 32'd1664525;
  localparam logic [31:0] LCG_INC     = 32'd1013904223;
  localparam int unsigned SEED_TOP    = 9999;
  localparam logic [7:0]  NONE_DRAWN  = 8'hFF;
  localparam int          SETTLE      = 60;
  localparam int          LONG_HOLD   = 3000;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  id;
    logic [2:0]  grp;
    logic [9:0]  rnd;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  id;
    logic [2:0]  grp;
    logic        mir;
    status_e     st;
  } pick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // item_id, item_group, round, pad
  logic [1:0]  s_axis_tuser = '0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // drawn_id, drawn_group, mirrored, pad
  logic [1:0]  m_axis_tuser;        // status
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  shuffle_bag_picker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, a shadow copy of the bag and its generator
  logic [6:0]  bag_id_q  [DEPTH];
  logic [2:0]  bag_grp_q [DEPTH];
  int unsigned bag_fill;
  int unsigned draw_slot;
  logic [7:0]  last_drawn;
  logic [31:0] lcg_word;
  logic [13:0] seed_reg;
  logic [9:0]  chance_reg;
  logic [9:0]  always_reg;

  cmd_t  cmd_queue[$];
  pick_t expected_picks[$];
  cmd_t  cur_cmd;

  int fail_count;
  int n_accepted, n_settings, n_draws, n_empty, n_dropped, n_mirrored;

  function automatic logic [15:0] lcg_yield();
    lcg_word = lcg_word * LCG_MULT + LCG_INC;
    return lcg_word[31:16];
  endfunction

  function automatic int unsigned lcg_range(int unsigned m);
    if (m == 0) return 0;
    return lcg_yield() % (m + 1);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [6:0] t_id;
    logic [2:0] t_grp;
    t_id = bag_id_q[a];   bag_id_q[a] = bag_id_q[b];   bag_id_q[b] = t_id;
    t_grp = bag_grp_q[a]; bag_grp_q[a] = bag_grp_q[b]; bag_grp_q[b] = t_grp;
  endfunction

  function automatic void shuffle_shadow();
    int unsigned j;
    for (int unsigned i = bag_fill; i > 1; i--) begin
      j = lcg_range(i - 1);
      swap_slots(i - 1, j);
    end
    draw_slot = 0;
  endfunction

  function automatic pick_t predict_pick(cmd_t c);
    pick_t p;
    logic [31:0] s;
    p = '{id: '0, grp: '0, mir: 1'b0, st: ST_OK};
    case (c.kind)
      KIND_CLEAR: begin
        bag_fill = 0;
        draw_slot = 0;
      end
      KIND_APPEND: begin
        if (bag_fill >= DEPTH) begin
          p.st = ST_DROP;
          n_dropped++;
        end else begin
          bag_id_q[bag_fill] = c.id;
          bag_grp_q[bag_fill] = c.grp;
          bag_fill++;
        end
      end
      KIND_START: begin
        s = 32'(seed_reg);
        if (s > SEED_TOP) s = s - (SEED_TOP + 1);
        lcg_word = s * SEED_MULT + 32'd1;
        shuffle_shadow();
        last_drawn = NONE_DRAWN;
      end
      default: begin
        if (bag_fill == 0) begin
          p.st = ST_EMPTY;
          n_empty++;
        end else begin
          if (draw_slot >= bag_fill) begin
            shuffle_shadow();
            // avoid repeating the previous item across a reshuffle
            if (bag_fill > 1 && {1'b0, bag_id_q[0]} == last_drawn) swap_slots(0, bag_fill - 1);
          end
          p.id = bag_id_q[draw_slot];
          p.grp = bag_grp_q[draw_slot];
          draw_slot++;
          last_drawn = {1'b0, p.id};
          if (c.rnd >= always_reg) p.mir = 1'b1;
          else if (c.rnd >= chance_reg) p.mir = lcg_range(1) != 0;
          n_draws++;
          if (p.mir) n_mirrored++;
        end
      end
    endcase
    return p;
  endfunction

  // Stimulus-side helpers
  int unsigned calm_tx, calm_rx;

  function automatic int pick_gap();
    int r;
    if (calm_tx > 0) begin
      calm_tx--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_tx = $urandom_range(20, 40);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [9:0] pick_round();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 35) v = int'(chance_reg) + $urandom_range(0, 4) - 2;
    else if (r < 65) v = int'(always_reg) + $urandom_range(0, 4) - 2;
    else if (r < 80) v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
    else v = $urandom_range(0, 1023);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  task automatic push_cmd(kind_e k, logic [6:0] id, logic [2:0] grp, logic [9:0] rnd);
    cmd_t c;
    c.kind = k;
    c.id = id;
    c.grp = grp;
    c.rnd = rnd;
    cmd_queue.push_back(c);
  endtask

  task automatic push_random(int n);
    int added, n_app, n_drw, r;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        // well-formed run: fill the bag, usually start, then draw, often past its end
        if ($urandom_range(0, 99) < 80) begin
          push_cmd(KIND_CLEAR, 7'($urandom), 3'($urandom), pick_round());
          added++;
        end
        r = $urandom_range(0, 99);
        if (r < 70) n_app = $urandom_range(1, 6);
        else if (r < 92) n_app = $urandom_range(7, 16);
        else n_app = $urandom_range(30, 36);
        for (int i = 0; i < n_app; i++)
          push_cmd(KIND_APPEND, 7'($urandom), 3'($urandom), pick_round());
        added += n_app;
        if ($urandom_range(0, 99) < 85) begin
          push_cmd(KIND_START, 7'($urandom), 3'($urandom), pick_round());
          added++;
        end
        n_drw = $urandom_range(1, 2 * n_app + 2);
        if (n_drw > 40) n_drw = 40;
        for (int i = 0; i < n_drw; i++) begin
          r = $urandom_range(0, 99);
          if (r < 4) push_cmd(KIND_START, 7'($urandom), 3'($urandom), pick_round());
          else if (r < 8) push_cmd(KIND_APPEND, 7'($urandom), 3'($urandom), pick_round());
          else push_cmd(KIND_DRAW, 7'($urandom), 3'($urandom), pick_round());
        end
        added += n_drw;
      end else begin
        push_cmd(kind_e'($urandom_range(0, 3)), 7'($urandom), 3'($urandom), pick_round());
        added++;
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SEED:          seed_reg = val[13:0];
      REG_MIRROR_CHANCE: chance_reg = val[9:0];
      default:           always_reg = val[9:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] seed, logic [CFG_W-1:0] chance,
                          logic [CFG_W-1:0] always_from);
    write_reg(REG_SEED, seed);
    write_reg(REG_MIRROR_CHANCE, chance);
    write_reg(REG_MIRROR_ALWAYS, always_from);
    n_settings++;
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || s_axis_tvalid || expected_picks.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Driver: offer items from the queue, predict each one as it is accepted
  int tx_gap;

  always @(posedge clk_i) begin : drive_items
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_picks.push_back(predict_pick(cur_cmd));
        n_accepted++;
        tx_gap = pick_gap();
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          s_axis_tdata <= {4'b0, cur_cmd.rnd, cur_cmd.grp, cur_cmd.id};
          s_axis_tuser <= cur_cmd.kind;
          nxt_valid = 1'b1;
        end
        s_axis_tvalid <= nxt_valid;
      end
    end
  end

  // Receiver: random back-pressure, with two long hold-offs to fill the block
  int rx_hold;
  int rx_seen;

  always @(posedge clk_i) begin : drive_ready
    int r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_seen++;
        if (rx_seen == 60 || rx_seen == 350) rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (calm_rx > 0) begin
        calm_rx--;
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_rx = $urandom_range(20, 40);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          rx_hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_picks
    pick_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: drawn_id %0d status %0d", m_axis_tdata[6:0], m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_picks.pop_front();
        if (m_axis_tdata[6:0] !== want.id) begin
          $error("drawn_id: expected %0d, got %0d", want.id, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tdata[9:7] !== want.grp) begin
          $error("drawn_group: expected %0d, got %0d", want.grp, m_axis_tdata[9:7]);
          fail_count++;
        end
        if (m_axis_tdata[10] !== want.mir) begin
          $error("mirrored: expected %0d, got %0d", want.mir, m_axis_tdata[10]);
          fail_count++;
        end
        if (m_axis_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < DEPTH; i++) begin
      bag_id_q[i] = '0;
      bag_grp_q[i] = '0;
    end
    bag_fill = 0;
    draw_slot = 0;
    last_drawn = NONE_DRAWN;
    lcg_word = '0;
    seed_reg = '0;
    chance_reg = 10'd8;
    always_reg = 10'd12;
    fail_count = 0;
    tx_gap = 0;
    rx_hold = 0;
    rx_seen = 0;
    calm_tx = 0;
    calm_rx = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // Directed: empty bag, draws before any start, thresholds, clear, single entry
    set_regs(14'd4321, 14'd8, 14'd12);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd0);
    push_cmd(KIND_APPEND, 7'd127, 3'd7, 10'd1023);
    push_cmd(KIND_APPEND, 7'd0,   3'd0, 10'd0);
    push_cmd(KIND_APPEND, 7'd85,  3'd5, 10'd341);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd0);
    push_cmd(KIND_DRAW,   7'd127, 3'd7, 10'd1023);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd8);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd12);
    push_cmd(KIND_START,  7'd42,  3'd2, 10'd682);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd11);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd7);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd12);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd9);
    push_cmd(KIND_CLEAR,  7'd127, 3'd7, 10'd1023);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd1023);
    push_cmd(KIND_APPEND, 7'd42,  3'd2, 10'd0);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd8);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd8);
    push_cmd(KIND_START,  7'd0,   3'd0, 10'd0);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd0);
    push_cmd(KIND_APPEND, 7'd1,   3'd3, 10'd0);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd12);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd13);
    push_cmd(KIND_DRAW,   7'd0,   3'd0, 10'd8);
    wait_idle();

    // Random phases; seeds above the limit and inverted thresholds among them
    set_regs(14'd16383, 14'd0, 14'd1023);
    push_random(100);
    wait_idle();
    set_regs(14'd0, 14'd1023, 14'd0);
    push_random(100);
    wait_idle();
    set_regs(14'd9999, 14'd5, 14'd5);
    push_random(100);
    wait_idle();
    set_regs(14'd10000, 14'd1023, 14'd1023);
    push_random(100);
    wait_idle();
    for (int ph = 0; ph < 2; ph++) begin
      set_regs(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
               14'($urandom_range(0, 16383)));
      push_random(100);
      wait_idle();
    end

    $display("Checked %0d commands over %0d register settings:", n_accepted, n_settings);
    $display("  %0d draws (%0d mirrored), %0d empty-bag draws, %0d dropped appends.",
             n_draws, n_mirrored, n_empty, n_dropped);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/sbp_pkg.sv
design/sbp_ram.sv
design/sbp_gen.sv
design/shuffle_bag_picker.sv
tb/testbench.sv
